[hdl/scsp_pkg.sv]
package scsp_pkg;

    // table geometry
    localparam int TABLE_SAMPLES = 32;
    localparam int IDX_W         = $clog2(TABLE_SAMPLES);
    localparam int ROM_W         = 12;

    // field and register widths
    localparam int PERIOD_W = 16;
    localparam int PCT_W    = 7;
    localparam int DC_W     = 8;
    localparam int REP_W    = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // serial divider geometry
    localparam int DIV_N_W = 28;
    localparam int DIV_D_W = 12;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMP    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 8'd3;

    // register reset values
    localparam logic [PERIOD_W-1:0] RST_PERIOD = 16'd479;
    localparam logic [PCT_W-1:0]    RST_AMP    = 7'd80;
    localparam logic [DC_W-1:0]     RST_OFFSET = 8'd0;
    localparam logic [REP_W-1:0]    RST_REPEAT = 8'd8;

    // scaling constants
    localparam logic [DIV_D_W-1:0] PCT_DIVISOR  = 12'd200;
    localparam logic [DIV_D_W-1:0] FULL_SCALE   = 12'd4095;
    localparam logic [DIV_N_W-1:0] ROUND_BIAS   = 28'd2047;
    localparam logic [PCT_W-1:0]   PCT_MAX      = 7'd100;
    localparam logic [PCT_W-1:0]   PCT_MIN      = 7'd1;
    localparam logic signed [DC_W-1:0] DC_MAX   = 8'sd100;
    localparam logic signed [DC_W-1:0] DC_MIN   = -8'sd100;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DC_GO,
        ST_DC_WAIT,
        ST_AMP_GO,
        ST_AMP_WAIT,
        ST_SCALE,
        ST_OUT_GO,
        ST_OUT_WAIT,
        ST_EMIT
    } t_state;

    // one period of the sine, 12-bit unsigned, centered on 2048
    function automatic logic [ROM_W-1:0] sine_rom(input logic [IDX_W-1:0] idx);
        logic [ROM_W-1:0] val;
        case (idx)
            5'd0:  val = 12'd2048;
            5'd1:  val = 12'd2447;
            5'd2:  val = 12'd2831;
            5'd3:  val = 12'd3185;
            5'd4:  val = 12'd3495;
            5'd5:  val = 12'd3750;
            5'd6:  val = 12'd3939;
            5'd7:  val = 12'd4056;
            5'd8:  val = 12'd4095;
            5'd9:  val = 12'd4056;
            5'd10: val = 12'd3939;
            5'd11: val = 12'd3750;
            5'd12: val = 12'd3495;
            5'd13: val = 12'd3185;
            5'd14: val = 12'd2831;
            5'd15: val = 12'd2447;
            5'd16: val = 12'd2048;
            5'd17: val = 12'd1649;
            5'd18: val = 12'd1265;
            5'd19: val = 12'd911;
            5'd20: val = 12'd601;
            5'd21: val = 12'd346;
            5'd22: val = 12'd157;
            5'd23: val = 12'd40;
            5'd24: val = 12'd0;
            5'd25: val = 12'd40;
            5'd26: val = 12'd157;
            5'd27: val = 12'd346;
            5'd28: val = 12'd601;
            5'd29: val = 12'd911;
            5'd30: val = 12'd1265;
            5'd31: val = 12'd1649;
            default: val = 12'd2048;
        endcase
        return val;
    endfunction

endpackage

[hdl/scaled_sine_pwm_sequencer.sv]
// Scaled sine PWM sequencer.
// Input stream: one word per PWM carrier period, s_axis_tdata[0] = carrier tick.
// Words with the tick clear are taken and dropped. A repetition counter passes
// every (repeat_count+1)-th tick; the first tick after reset passes.
// Output stream: one word per passed tick, carrying the scaled compare value,
// the sine table position it came from, and tlast on the last table position.
// Configuration: i_cfg_we writes register i_cfg_idx (0 period, 1 amplitude,
// 2 offset, 3 repeat count) from i_cfg_data; other indexes are ignored.
// Each sample is computed by three divisions (by 200, 200 and 4095) run one
// after the other on a single 28-bit restoring divider at one bit per cycle,
// plus multiply, scale and load steps. s_axis_tready is low while a sample is
// computed, so no new tick is taken until it is loaded into the output register.
// A finished sample sits in the output register; a new tick is taken while it
// waits. If the receiver stalls, the next sample holds in the last step until
// the output register frees.
// Reset (synchronous, active low) restores register defaults, clears the table
// position and the repetition counter, and drops any pending output word.
module scaled_sine_pwm_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [scsp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [scsp_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    // tick stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [0] carrier_tick
    // sample stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata,   // [15:0] compare_value,
                                                              // [20:16] sample_index
    output logic                              m_axis_tlast    // cycle_end
);
    import scsp_pkg::*;

    // configuration registers
    logic [PERIOD_W-1:0]    r_period;
    logic [PCT_W-1:0]       r_amp_pct;
    logic [DC_W-1:0]        r_offset;
    logic [REP_W-1:0]       r_repeat;

    // sequencing state
    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_pos;
    logic [IDX_W-1:0]       r_idx;
    logic [REP_W-1:0]       r_rep_left;

    // datapath
    logic                   r_dc_neg;
    logic [22:0]            r_prod_dc;
    logic [22:0]            r_prod_amp;
    logic signed [18:0]     r_mid;
    logic [14:0]            r_amp;
    logic [DIV_N_W-1:0]     r_num;
    logic [PERIOD_W-1:0]    r_cmp;

    // output register
    logic                   r_m_valid;
    logic [23:0]            r_m_data;
    logic                   r_m_last;

    // divider hookup
    logic                   w_div_start;
    logic [DIV_N_W-1:0]     w_div_n;
    logic [DIV_D_W-1:0]     w_div_d;
    logic                   w_div_done;
    logic [DIV_N_W-1:0]     w_div_q;

    logic                   w_accept;
    logic                   w_out_free;
    logic signed [DC_W-1:0] w_dc;
    logic signed [DC_W-1:0] w_dc_neg;
    logic [PCT_W-1:0]       w_dc_mag;
    logic [PCT_W-1:0]       w_pct;
    logic [ROM_W-1:0]       w_base;
    logic [26:0]            w_amp_base;
    logic signed [18:0]     w_off;
    logic signed [18:0]     w_v;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;

    // clamp the percentages to their legal ranges
    always_comb begin
        w_dc = signed'(r_offset);
        if (w_dc < DC_MIN) begin
            w_dc = DC_MIN;
        end else if (w_dc > DC_MAX) begin
            w_dc = DC_MAX;
        end
        w_dc_neg = DC_W'(0) - w_dc;
        w_dc_mag = w_dc[DC_W-1] ? w_dc_neg[PCT_W-1:0] : w_dc[PCT_W-1:0];

        w_pct = r_amp_pct;
        if (w_pct < PCT_MIN) begin
            w_pct = PCT_MIN;
        end else if (w_pct > PCT_MAX) begin
            w_pct = PCT_MAX;
        end
    end

    // scaling arithmetic
    always_comb begin
        w_base     = sine_rom(r_idx);
        w_amp_base = {12'd0, r_amp} * {15'd0, w_base};
        w_off      = r_dc_neg ? -$signed({3'd0, w_div_q[15:0]})
                              :  $signed({3'd0, w_div_q[15:0]});
        w_v        = r_mid - $signed({4'd0, r_amp}) + $signed({3'd0, w_div_q[15:0]});
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= RST_PERIOD;
            r_amp_pct <= RST_AMP;
            r_offset  <= RST_OFFSET;
            r_repeat  <= RST_REPEAT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PERIOD: r_period  <= i_cfg_data;
                REG_AMP:    r_amp_pct <= i_cfg_data[PCT_W-1:0];
                REG_OFFSET: r_offset  <= i_cfg_data[DC_W-1:0];
                REG_REPEAT: r_repeat  <= i_cfg_data[REP_W-1:0];
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and divider control
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_div_start   = 1'b0;
        w_div_n       = {5'd0, r_prod_dc};
        w_div_d       = PCT_DIVISOR;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (w_accept && s_axis_tdata[0] && (r_rep_left == '0)) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:   n_state = ST_DC_GO;
            ST_DC_GO: begin
                w_div_start = 1'b1;
                n_state     = ST_DC_WAIT;
            end
            ST_DC_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_AMP_GO;
                end
            end
            ST_AMP_GO: begin
                w_div_start = 1'b1;
                w_div_n     = {5'd0, r_prod_amp};
                n_state     = ST_AMP_WAIT;
            end
            ST_AMP_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: n_state = ST_OUT_GO;
            ST_OUT_GO: begin
                w_div_start = 1'b1;
                w_div_n     = r_num;
                w_div_d     = FULL_SCALE;
                n_state     = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // tick counting and table position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_rep_left <= '0;
        end else if (w_accept && s_axis_tdata[0]) begin
            if (r_rep_left != '0) begin
                r_rep_left <= r_rep_left - 1'b1;
            end else begin
                r_rep_left <= r_repeat;
                r_pos      <= r_pos + 1'b1;
            end
        end
    end

    // per-sample datapath
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_idx <= r_pos;
        end
        if (r_state == ST_MUL) begin
            r_dc_neg   <= w_dc[DC_W-1];
            r_prod_dc  <= {7'd0, r_period} * {16'd0, w_dc_mag};
            r_prod_amp <= {7'd0, r_period} * {16'd0, w_pct};
        end
        if (r_state == ST_DC_WAIT && w_div_done) begin
            r_mid <= $signed({3'd0, r_period >> 1}) + w_off;
        end
        if (r_state == ST_AMP_WAIT && w_div_done) begin
            r_amp <= w_div_q[14:0];
        end
        if (r_state == ST_SCALE) begin
            r_num <= {w_amp_base, 1'b0} + ROUND_BIAS;
        end
        if (r_state == ST_OUT_WAIT && w_div_done) begin
            if (w_v < 0) begin
                r_cmp <= '0;
            end else if (w_v > $signed({3'd0, r_period})) begin
                r_cmp <= r_period;
            end else begin
                r_cmp <= w_v[PERIOD_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == ST_EMIT && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && w_out_free) begin
            r_m_data <= {3'd0, r_idx, r_cmp};
            r_m_last <= (r_idx == IDX_W'(TABLE_SAMPLES - 1));
        end
    end

    scsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_n),
        .i_divisor  (w_div_d),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

endmodule

[hdl/scsp_div.sv]
// Restoring divider, one quotient bit per cycle, MSB first.
module scsp_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [scsp_pkg::DIV_N_W-1:0]    i_dividend,
    input  logic [scsp_pkg::DIV_D_W-1:0]    i_divisor,
    output logic                            o_done,
    output logic [scsp_pkg::DIV_N_W-1:0]    o_quotient
);
    import scsp_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [DIV_N_W-1:0]     r_quo;     // dividend bits out at top, quotient bits in at bottom
    logic [DIV_D_W-1:0]     r_rem;
    logic [DIV_D_W-1:0]     r_dsr;

    logic [DIV_D_W:0]       w_rem_sh;
    logic                   w_ge;
    logic [DIV_D_W:0]       w_diff;

    // one trial subtraction
    always_comb begin
        w_rem_sh = {r_rem, r_quo[DIV_N_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_dsr});
        w_diff   = w_rem_sh - {1'b0, r_dsr};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_N_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_N_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIV_D_W-1:0] : w_rem_sh[DIV_D_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hdl/scsp_chk.sv]
// Port-level checks for the sequencer.
module scsp_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [23:0]                       m_axis_tdata,
    input  logic                              m_axis_tlast
);
    import scsp_pkg::*;

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid right after reset");

    // reset leaves the input side ready for a word
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready right after reset");

    // tlast marks exactly the last table position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast ==
                           (m_axis_tdata[20:16] == IDX_W'(TABLE_SAMPLES - 1))))
        else $error("tlast does not match sample index");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:21] == 3'd0))
        else $error("tdata padding not zero");

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

endmodule

bind scaled_sine_pwm_sequencer scsp_chk u_scsp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[sim/scaled_sine_pwm_sequencer_tb.sv]
`timescale 1ns / 1ps

module scaled_sine_pwm_sequencer_tb;
    import scsp_pkg::*;

    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 120;      // past the sample latency
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int HOLD_CYCLES   = 1500;     // long output stall
    localparam int HOLD_TICKS    = 25;
    localparam int PHASES        = 10;
    localparam int PHASE_TICKS   = 180;
    localparam int SLOW_PHASE    = 3;        // repeat count at its top
    localparam int HOLD_PHASE    = 5;        // output stall follows this phase
    localparam int PCT_SCALE     = 200;
    localparam int ROUND_HALF    = 2047;
    localparam int ROM_FULL      = 4095;

    // writes here must leave every register alone
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 8'hFF;
    localparam logic [IDX_W-1:0]     LAST_POS     = 5'd31;

    // offset register codes at and beyond its limits
    localparam logic [DC_W-1:0] OFS_NEG_WRAP = 8'h80;   // -128
    localparam logic [DC_W-1:0] OFS_NEG_MAX  = 8'h9C;   // -100
    localparam logic [DC_W-1:0] OFS_POS_MAX  = 8'd100;
    localparam logic [DC_W-1:0] OFS_POS_WRAP = 8'h7F;   // 127

    typedef struct packed {
        logic [15:0]      compare;
        logic [IDX_W-1:0] index;
        logic             cycle_end;
    } t_sample;

    typedef enum logic {ROW_TICK, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DAT_W-1:0]  data;
        logic                  tick;
        logic                  typed;    // compare value given by hand
        logic [15:0]           want;
    } t_row;

    localparam int SCRIPT_ROWS = 32;

    // directed opening: reset behavior, countdown, clamps, odd register codes
    t_row script [SCRIPT_ROWS] = '{
        '{ROW_TICK,  REG_PERIOD,   16'h0000, 1'b0, 1'b0, 16'd0},    // no event after reset
        '{ROW_WRITE, REG_REPEAT,   16'd2,    1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_PERIOD,   16'h0000, 1'b1, 1'b1, 16'd239},  // first tick emits
        '{ROW_WRITE, REG_REPEAT,   16'd0,    1'b0, 1'b0, 16'd0},    // old countdown runs out
        '{ROW_TICK,  REG_PERIOD,   16'h0000, 1'b1, 1'b0, 16'd0},
        '{ROW_TICK,  REG_PERIOD,   16'h0000, 1'b1, 1'b0, 16'd0},
        '{ROW_TICK,  REG_PERIOD,   16'h0000, 1'b1, 1'b0, 16'd0},
        '{ROW_TICK,  REG_PERIOD,   16'h0000, 1'b1, 1'b0, 16'd0},
        '{ROW_WRITE, REG_PERIOD,   16'd0,    1'b0, 1'b0, 16'd0},    // zero period
        '{ROW_TICK,  REG_PERIOD,   16'h0000, 1'b1, 1'b1, 16'd0},
        '{ROW_TICK,  REG_PERIOD,   16'h0000, 1'b1, 1'b1, 16'd0},
        '{ROW_WRITE, REG_PERIOD,   16'hFFFF, 1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, REG_AMP,      16'd100,  1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, REG_OFFSET,   16'd100,  1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_PERIOD,   16'h0000, 1'b1, 1'b1, 16'hFFFF}, // clamped at the top
        '{ROW_TICK,  REG_PERIOD,   16'h0000, 1'b1, 1'b1, 16'hFFFF},
        '{ROW_TICK,  REG_PERIOD,   16'h0000, 1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, REG_OFFSET,   16'hFF9C, 1'b0, 1'b0, 16'd0},    // -100, junk above
        '{ROW_TICK,  REG_PERIOD,   16'h0000, 1'b1, 1'b0, 16'd0},
        '{ROW_WRITE, REG_AMP,      16'hFF80, 1'b0, 1'b0, 16'd0},    // zero acts as one
        '{ROW_WRITE, REG_OFFSET,   16'h0080, 1'b0, 1'b0, 16'd0},    // -128 acts as -100
        '{ROW_TICK,  REG_PERIOD,   16'h0000, 1'b1, 1'b0, 16'd0},
        '{ROW_WRITE, REG_AMP,      16'd127,  1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, REG_OFFSET,   16'h007F, 1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_PERIOD,   16'h0000, 1'b1, 1'b0, 16'd0},
        '{ROW_WRITE, REG_SPARE_LO, 16'd0,    1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, REG_SPARE_HI, 16'hFFFF, 1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_PERIOD,   16'h0000, 1'b1, 1'b0, 16'd0},
        '{ROW_WRITE, REG_PERIOD,   16'd1,    1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, REG_AMP,      16'd50,   1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, REG_OFFSET,   16'd0,    1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_PERIOD,   16'h0000, 1'b1, 1'b0, 16'd0}
    };

    logic [ROM_W-1:0] sine_lut [TABLE_SAMPLES] = '{
        12'd2048, 12'd2447, 12'd2831, 12'd3185, 12'd3495, 12'd3750, 12'd3939, 12'd4056,
        12'd4095, 12'd4056, 12'd3939, 12'd3750, 12'd3495, 12'd3185, 12'd2831, 12'd2447,
        12'd2048, 12'd1649, 12'd1265, 12'd911,  12'd601,  12'd346,  12'd157,  12'd40,
        12'd0,    12'd40,   12'd157,  12'd346,  12'd601,  12'd911,  12'd1265, 12'd1649
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DAT_W-1:0]  i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;    // [0] carrier_tick
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;    // [15:0] compare_value, [20:16] sample_index
    logic                  m_axis_tlast;    // cycle_end

    // mirror of the block's registers and sequencing state
    logic [PERIOD_W-1:0]      cfg_period;
    logic [PCT_W-1:0]         cfg_amp;
    logic signed [DC_W-1:0]   cfg_offset;
    logic [REP_W-1:0]         cfg_repeat;
    logic [IDX_W-1:0]         next_pos;
    logic [REP_W-1:0]         skips_left;

    t_sample expected_samples [$];

    int  mismatch_count  = 0;
    int  samples_checked = 0;
    int  ticks_sent      = 0;
    int  writes_done     = 0;
    int  cycle_count     = 0;
    int  hold_request    = 0;
    int  hold_left       = 0;
    int  ready_gap       = 0;
    bit  steady          = 1'b0;   // no idling on either side

    scaled_sine_pwm_sequencer dut (.*);

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    function automatic void restore_defaults();
        cfg_period = RST_PERIOD;
        cfg_amp    = RST_AMP;
        cfg_offset = RST_OFFSET;
        cfg_repeat = RST_REPEAT;
        next_pos   = '0;
        skips_left = '0;
    endfunction

    // table entry scaled into 0..period with rounding and clamps
    function automatic logic [15:0] scaled_compare(input logic [ROM_W-1:0] base);
        int top, pct, dc, mid, swing, v;
        top = int'(cfg_period);
        pct = int'(cfg_amp);
        dc  = int'(cfg_offset);
        if (pct < 1) pct = 1;
        if (pct > 100) pct = 100;
        if (dc < -100) dc = -100;
        if (dc > 100) dc = 100;
        mid   = top / 2 + (top * dc) / PCT_SCALE;
        swing = (top * pct) / PCT_SCALE;
        v     = (mid - swing) + (2 * swing * int'(base) + ROUND_HALF) / ROM_FULL;
        if (v < 0) v = 0;
        if (v > top) v = top;
        return v[15:0];
    endfunction

    // one tick word through the repeat counter; returns 1 when a sample comes out
    function automatic bit advance_tick(input bit tick, output t_sample s);
        s = '0;
        if (!tick) return 1'b0;
        if (skips_left != 0) begin
            skips_left--;
            return 1'b0;
        end
        skips_left  = cfg_repeat;
        s.compare   = scaled_compare(sine_lut[next_pos]);
        s.index     = next_pos;
        s.cycle_end = (next_pos == LAST_POS);
        next_pos++;
        return 1'b1;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_PERIOD: cfg_period = data;
            REG_AMP:    cfg_amp    = data[PCT_W-1:0];
            REG_OFFSET: cfg_offset = data[DC_W-1:0];
            REG_REPEAT: cfg_repeat = data[REP_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        writes_done++;
    endtask

    task automatic put_tick(input bit tick, input bit typed, input logic [15:0] want);
        t_sample s;
        int      gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, tick};
        do @(posedge i_clk); while (!s_axis_tready);
        if (advance_tick(tick, s)) begin
            if (typed) s.compare = want;
            expected_samples.push_back(s);
        end
        ticks_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drop valid, drain, then let any skipped tick finish before touching registers
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_settings(input bit slowest);
        logic [CFG_DAT_W-1:0] word;
        logic [PCT_W-1:0]     amp;
        logic [DC_W-1:0]      ofs;
        int                   r;

        case ($urandom_range(0, 5))
            0:       word = 16'd0;
            1:       word = 16'd1;
            2:       word = 16'hFFFF;
            default: word = CFG_DAT_W'($urandom_range(0, 65535));
        endcase
        cfg_write(REG_PERIOD, word);

        case ($urandom_range(0, 5))
            0:       amp = 7'd0;
            1:       amp = PCT_MIN;
            2:       amp = PCT_MAX;
            3:       amp = 7'd127;
            default: amp = PCT_W'($urandom_range(1, 100));
        endcase
        word = CFG_DAT_W'($urandom());
        word[PCT_W-1:0] = amp;
        cfg_write(REG_AMP, word);

        r = $urandom_range(0, 200);
        case ($urandom_range(0, 5))
            0:       ofs = OFS_NEG_WRAP;
            1:       ofs = OFS_NEG_MAX;
            2:       ofs = OFS_POS_MAX;
            3:       ofs = OFS_POS_WRAP;
            default: ofs = DC_W'(r - 100);
        endcase
        word = CFG_DAT_W'($urandom());
        word[DC_W-1:0] = ofs;
        cfg_write(REG_OFFSET, word);

        word = CFG_DAT_W'($urandom());
        if (slowest) word[REP_W-1:0] = 8'd255;
        else if ($urandom_range(0, 4) == 0) word[REP_W-1:0] = REP_W'($urandom_range(0, 255));
        else word[REP_W-1:0] = REP_W'($urandom_range(0, 3));
        cfg_write(REG_REPEAT, word);

        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                      CFG_DAT_W'($urandom()));
    endtask

    // sample sink: check each accepted word, then choose the next ready level
    always @(posedge i_clk) begin : sample_sink
        t_sample want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch("unexpected sample word, compare_value",
                                int'(m_axis_tdata[15:0]), 0);
            end else begin
                want = expected_samples.pop_front();
                samples_checked++;
                if (m_axis_tdata[15:0] !== want.compare)
                    report_mismatch("compare_value", int'(m_axis_tdata[15:0]),
                                    int'(want.compare));
                if (m_axis_tdata[20:16] !== want.index)
                    report_mismatch("sample_index", int'(m_axis_tdata[20:16]),
                                    int'(want.index));
                if (m_axis_tlast !== want.cycle_end)
                    report_mismatch("cycle_end", int'(m_axis_tlast), int'(want.cycle_end));
            end
        end
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (ready_gap != 0) begin
            ready_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            ready_gap = pick_gap();
            m_axis_tready <= (ready_gap == 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d samples still due",
                     cycle_count, expected_samples.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stimulus
        bit last_was_tick;
        int p;
        int k;

        last_was_tick = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        restore_defaults();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        for (k = 0; k < SCRIPT_ROWS; k++) begin
            if (script[k].kind == ROW_WRITE) begin
                if (last_was_tick) settle();
                cfg_write(script[k].idx, script[k].data);
                last_was_tick = 1'b0;
            end else begin
                put_tick(script[k].tick, script[k].typed, script[k].want);
                last_was_tick = 1'b1;
            end
        end

        // random phases, each under fresh register settings
        for (p = 0; p < PHASES; p++) begin
            settle();
            steady = 1'b0;
            random_settings(p == SLOW_PHASE);
            steady = (p % 4 == 2);
            for (k = 0; k < PHASE_TICKS; k++)
                put_tick($urandom_range(0, 99) < 85, 1'b0, 16'd0);

            // receiver stalls for a long stretch while ticks keep coming
            if (p == HOLD_PHASE) begin
                settle();
                cfg_write(REG_REPEAT, 16'd0);
                steady       = 1'b1;
                hold_request = HOLD_CYCLES;
                for (k = 0; k < HOLD_TICKS; k++)
                    put_tick(1'b1, 1'b0, 16'd0);
            end
        end
        steady = 1'b0;
        settle();

        $display("%0d tick words sent across %0d register writes; %0d sample words checked",
                 ticks_sent, writes_done, samples_checked);
        $display("covered period/amplitude/offset extremes, repeat 0..255, one long output stall");
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
